// File: sv/gif_lzw_encoder_macros.svh
// Assertion macros used by the port-level checker file
`ifndef GIF_LZW_ENCODER_MACROS_SVH
`define GIF_LZW_ENCODER_MACROS_SVH

// same-cycle implication, off during reset
`define GLE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define GLE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, also checked while reset is applied
`define GLE_ASSERT_NXT_ALL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/gle_pkg.sv
// Package: types and constants of the GIF LZW encoder
package gle_pkg;

  localparam int HASH_SLOTS_DEF = 8192;
  localparam int CODE_LIMIT_DEF = 4096;
  localparam int HASH_SHIFT     = 19;

  localparam logic [11:0] CLEAR_CODE  = 12'd256;
  localparam logic [11:0] END_CODE    = 12'd257;
  localparam logic [12:0] FIRST_FREE  = 13'd258;
  localparam logic [3:0]  START_WIDTH = 4'd9;
  localparam logic [3:0]  MAX_WIDTH   = 4'd12;
  localparam logic [31:0] HASH_MULT   = 32'd2654435761;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
    logic       frame_end;
  } gle_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_end;
  } gle_out_t;

  typedef struct packed {
    logic        valid;
    logic [11:0] prefix;
    logic [7:0]  suffix;
    logic [11:0] code;
  } gle_entry_t;

  // one code handed to the bit packer
  typedef struct packed {
    logic        valid;
    logic [11:0] code;
    logic [3:0]  width;
    logic        last;
    logic        fin;
  } gle_code_t;

endpackage

// File: sv/gle_dict.sv
// Dictionary hash table: one synchronous memory, registered read
module gle_dict import gle_pkg::*; #(
  parameter int HASH_SLOTS = HASH_SLOTS_DEF,
  localparam int IDX_W = $clog2(HASH_SLOTS)
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] rd_addr,
  output gle_entry_t       rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  gle_entry_t       wr_data
);

  gle_entry_t mem [HASH_SLOTS];
  gle_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/gle_packer.sv
// Bit packer: codes in LSB-first, bytes out through an output register
module gle_packer import gle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  gle_code_t code_req,
  input  logic      clr,
  output logic      idle,
  output logic      out_valid,
  output gle_out_t  out_data,
  input  logic      out_stall
);

  logic [23:0] buf_r, buf_nxt;
  logic [4:0]  fill_r, fill_nxt;
  logic        pad_r, pad_nxt;
  logic        lastf_r, lastf_nxt;
  logic        endf_r, endf_nxt;
  logic        ov_r, ov_nxt;
  gle_out_t    od_r, od_nxt;

  logic [12:0] mask;
  logic [11:0] masked;
  logic        can_load;
  logic [4:0]  rem;
  logic        is_last;

  assign idle     = (fill_r < 5'd8) && !pad_r;
  assign can_load = !ov_r || !out_stall;
  assign mask     = (13'd1 << code_req.width) - 13'd1;
  assign masked   = code_req.code & mask[11:0];
  assign rem      = fill_r - 5'd8;
  assign is_last  = lastf_r && (rem < 5'd8) && !(endf_r && (rem != 5'd0));

  always_comb begin
    buf_nxt   = buf_r;
    fill_nxt  = fill_r;
    pad_nxt   = pad_r;
    lastf_nxt = lastf_r;
    endf_nxt  = endf_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    if (clr) begin
      buf_nxt  = '0;
      fill_nxt = '0;
      pad_nxt  = 1'b0;
    end else if (code_req.valid && idle) begin
      buf_nxt   = buf_r | (24'(masked) << fill_r);
      fill_nxt  = fill_r + 5'(code_req.width);
      lastf_nxt = code_req.last;
      endf_nxt  = code_req.fin;
    end else if (pad_r && can_load) begin
      // zero-padded final byte of the frame
      od_nxt   = '{out_byte: buf_r[7:0], run_last: 1'b1, stream_end: 1'b1};
      ov_nxt   = 1'b1;
      buf_nxt  = '0;
      fill_nxt = '0;
      pad_nxt  = 1'b0;
    end else if ((fill_r >= 5'd8) && can_load) begin
      od_nxt   = '{out_byte: buf_r[7:0], run_last: is_last,
                   stream_end: is_last && endf_r};
      ov_nxt   = 1'b1;
      buf_nxt  = buf_r >> 8;
      fill_nxt = rem;
      if (lastf_r && endf_r && (rem < 5'd8) && (rem != 5'd0)) begin
        pad_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= '0;
      fill_r <= '0;
      pad_r  <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      buf_r  <= buf_nxt;
      fill_r <= fill_nxt;
      pad_r  <= pad_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lastf_r <= lastf_nxt;
    endf_r  <= endf_nxt;
    od_r    <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// File: sv/gif_lzw_encoder.sv
// GIF LZW encoder top: probe sequencer, code list, dictionary sweep.
// Per pixel (a frame-start pixel skips the probe): an accept state, then per
// slot probed an address state and a compare state after the registered
// dictionary read; a miss, or a hit on the frame end, then hands its codes to the packer one at a time.
// Frame start and a full dictionary run a clearing sweep over all HASH_SLOTS
// slots before the next pixel is taken; reset starts the same sweep.
module gif_lzw_encoder import gle_pkg::*; #(
  parameter int HASH_SLOTS = HASH_SLOTS_DEF,
  parameter int CODE_LIMIT = CODE_LIMIT_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  gle_in_t  in_data,
  output logic     out_valid,
  output gle_out_t out_data,
  input  logic     out_stall
);

  localparam int IDX_W = $clog2(HASH_SLOTS);
  localparam logic [12:0] LIMIT = 13'(CODE_LIMIT);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(HASH_SLOTS - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HASH  = 6'b000010,
    S_LOOK  = 6'b000100,
    S_CHK   = 6'b001000,
    S_EMIT  = 6'b010000,
    S_SWEEP = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [11:0]       cur_r, cur_nxt;
  logic [12:0]       nf_r, nf_nxt;
  logic [3:0]        w_r, w_nxt;
  logic              sweep_pend_r, sweep_pend_nxt;
  logic [IDX_W-1:0]  sw_r, sw_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [2:0]        cnt_r, cnt_nxt;
  logic [11:0]       lq_code_r [4];
  logic [11:0]       lq_code_nxt [4];
  logic [3:0]        lq_wid_r [4];
  logic [3:0]        lq_wid_nxt [4];
  logic [7:0]        pix_r, pix_nxt;
  logic              end_r, end_nxt;
  logic [31:0]       prod_r, prod_nxt;
  logic [IDX_W-1:0]  addr_r, addr_nxt;

  logic [IDX_W-1:0]  hash_idx;
  logic [IDX_W-1:0]  rd_addr;
  gle_entry_t        rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  gle_entry_t        wr_data;
  gle_code_t         pk_req;
  logic              pk_clr;
  logic              pk_idle;
  logic              accept;
  logic              item_last;

  assign hash_idx  = IDX_W'(prod_r[31:HASH_SHIFT]);
  assign in_stall  = !((state_r == S_IDLE) && pk_idle);
  assign accept    = in_valid && !in_stall;
  assign item_last = ({1'b0, idx_r} == (cnt_r - 3'd1));

  always_comb begin
    logic [2:0]  n;
    logic [3:0]  wn;
    logic [12:0] nfn;
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    nf_nxt         = nf_r;
    w_nxt          = w_r;
    sweep_pend_nxt = sweep_pend_r;
    sw_nxt         = sw_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    lq_code_nxt    = lq_code_r;
    lq_wid_nxt     = lq_wid_r;
    pix_nxt        = pix_r;
    end_nxt        = end_r;
    prod_nxt       = prod_r;
    addr_nxt       = addr_r;
    rd_addr        = addr_r;
    wr_en          = 1'b0;
    wr_addr        = addr_r;
    wr_data        = '0;
    pk_req         = '0;
    pk_clr         = 1'b0;
    n              = 3'd0;
    wn             = w_r;
    nfn            = nf_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pix_nxt  = in_data.pixel;
          end_nxt  = in_data.frame_end;
          prod_nxt = {12'b0, cur_r, in_data.pixel} * HASH_MULT;
          if (in_data.frame_start) begin
            pk_clr         = 1'b1;
            nf_nxt         = FIRST_FREE;
            w_nxt          = START_WIDTH;
            sweep_pend_nxt = 1'b1;
            lq_code_nxt[0] = CLEAR_CODE;
            lq_wid_nxt[0]  = START_WIDTH;
            lq_code_nxt[1] = {4'b0, in_data.pixel};
            lq_wid_nxt[1]  = START_WIDTH;
            lq_code_nxt[2] = END_CODE;
            lq_wid_nxt[2]  = START_WIDTH;
            cnt_nxt        = in_data.frame_end ? 3'd3 : 3'd1;
            cur_nxt        = in_data.frame_end ? 12'd0 : {4'b0, in_data.pixel};
            idx_nxt        = 2'd0;
            state_nxt      = S_EMIT;
          end else begin
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        rd_addr   = hash_idx;
        addr_nxt  = hash_idx;
        state_nxt = S_CHK;
      end
      S_LOOK: begin
        rd_addr   = addr_r;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        idx_nxt = 2'd0;
        if (rd_data.valid && (rd_data.prefix == cur_r) && (rd_data.suffix == pix_r)) begin
          if (end_r) begin
            lq_code_nxt[0] = rd_data.code;
            lq_wid_nxt[0]  = w_r;
            lq_code_nxt[1] = END_CODE;
            lq_wid_nxt[1]  = w_r;
            cnt_nxt        = 3'd2;
            cur_nxt        = 12'd0;
            state_nxt      = S_EMIT;
          end else begin
            cur_nxt   = rd_data.code;
            state_nxt = S_IDLE;
          end
        end else if (rd_data.valid) begin
          addr_nxt  = addr_r + 1'b1;
          state_nxt = S_LOOK;
        end else begin
          lq_code_nxt[0] = cur_r;
          lq_wid_nxt[0]  = w_r;
          if (nf_r < LIMIT) begin
            wr_en   = 1'b1;
            wr_addr = addr_r;
            wr_data = '{valid: 1'b1, prefix: cur_r, suffix: pix_r, code: nf_r[11:0]};
            nfn     = nf_r + 13'd1;
            if ((nfn > (13'd1 << w_r)) && (w_r < MAX_WIDTH)) begin
              wn = w_r + 4'd1;
            end
            n = 3'd1;
          end else begin
            // dictionary full: clear code, then start over
            lq_code_nxt[1] = CLEAR_CODE;
            lq_wid_nxt[1]  = w_r;
            nfn            = FIRST_FREE;
            wn             = START_WIDTH;
            sweep_pend_nxt = 1'b1;
            n              = 3'd2;
          end
          nf_nxt = nfn;
          w_nxt  = wn;
          if (end_r) begin
            lq_code_nxt[n[1:0]]        = {4'b0, pix_r};
            lq_wid_nxt[n[1:0]]         = wn;
            lq_code_nxt[n[1:0] + 2'd1] = END_CODE;
            lq_wid_nxt[n[1:0] + 2'd1]  = wn;
            cnt_nxt                    = n + 3'd2;
            cur_nxt                    = 12'd0;
          end else begin
            cnt_nxt = n;
            cur_nxt = {4'b0, pix_r};
          end
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        pk_req = '{valid: 1'b1, code: lq_code_r[idx_r], width: lq_wid_r[idx_r],
                   last: item_last, fin: end_r && item_last};
        if (pk_idle) begin
          idx_nxt = idx_r + 2'd1;
          if (item_last) begin
            idx_nxt   = 2'd0;
            state_nxt = sweep_pend_r ? S_SWEEP : S_IDLE;
          end
        end
      end
      S_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sw_r;
        wr_data = '0;
        sw_nxt  = sw_r + 1'b1;
        if (sw_r == LAST_SLOT) begin
          sw_nxt         = '0;
          sweep_pend_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_SWEEP;
      cur_r        <= '0;
      nf_r         <= FIRST_FREE;
      w_r          <= START_WIDTH;
      sweep_pend_r <= 1'b0;
      sw_r         <= '0;
      idx_r        <= '0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      cur_r        <= cur_nxt;
      nf_r         <= nf_nxt;
      w_r          <= w_nxt;
      sweep_pend_r <= sweep_pend_nxt;
      sw_r         <= sw_nxt;
      idx_r        <= idx_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lq_code_r <= lq_code_nxt;
    lq_wid_r  <= lq_wid_nxt;
    pix_r     <= pix_nxt;
    end_r     <= end_nxt;
    prod_r    <= prod_nxt;
    addr_r    <= addr_nxt;
  end

  gle_dict #(.HASH_SLOTS(HASH_SLOTS)) u_dict (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  gle_packer u_packer (
    .clk       (clk),
    .rst_n     (rst_n),
    .code_req  (pk_req),
    .clr       (pk_clr),
    .idle      (pk_idle),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

// File: sv/gle_checker.sv
// Port-level checker for the GIF LZW encoder, bound to the top level
`include "gif_lzw_encoder_macros.svh"

module gle_checker import gle_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input gle_out_t out_data,
  input logic     out_valid,
  input logic     out_stall
);

  `GLE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled output changed")
  `GLE_ASSERT_IMP(a_end_is_last, out_valid && out_data.stream_end, out_data.run_last, "stream end without run last")
  `GLE_ASSERT_NXT_ALL(a_reset_sweep, !rst_n, in_stall, "request taken during clearing sweep")
  `GLE_ASSERT_NXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "second request taken while busy")

endmodule

bind gif_lzw_encoder gle_checker u_gle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_stall (out_stall)
);
